### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define BDLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BDLP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bdlp_pkg.sv
// Package: constants, codes and types of the button debouncer.
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int BUTTONS_DEF    = 6;
    localparam int TIMER_BITS_DEF = 16;
    localparam int TIMER_BITS_MAX = 32;

    localparam int CFG_WIDTH      = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PIN_BITS       = 6;
    localparam int LONG_BITS      = 6;
    localparam int IDX_BITS       = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT        = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESSED_LEVEL = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd150;
    localparam logic [CFG_WIDTH-1:0] REPEAT_RST     = 16'd20;
    localparam logic                 PRESSED_RST    = 1'b0;
    localparam logic                 RELEASED_RST   = ~PRESSED_RST;

    typedef struct packed {
        logic tick;
        logic clear;
        logic pressed_level;
    } lane_ctrl_t;

    typedef struct packed {
        logic pending;
        logic long_next;
    } lane_status_t;

    typedef struct packed {
        logic                 pressed;
        logic [LONG_BITS-1:0] long_mode;
    } result_t;

endpackage

### hdl/button_debounce_long_press_repeat_core.sv
// Top level: debouncer for a bank of buttons with long-press auto-repeat.
//
// Input channel (s_*): each item is a tick (command 0) carrying one pin
// sample for each of the first six buttons (the rest see 0), or a read
// (command 1) that returns and clears the pressed flag of button
// s_button_index. Every item gives one result item on the m_* channel:
// the read flag (0 for ticks) and the long mode bits of the first six
// buttons after the update. The block takes one item per cycle while
// s_ready is high. Results go to an output register backed by a skid
// register, so one item is still taken while a result waits; s_ready
// drops only when both hold a result that the receiver has not taken.
// Configuration (cfg_*) writes long-press time, repeat time and the pin
// level for pressed; write only while the block is idle.
// Reset (aresetn low, synchronous) empties the result buffer, clears all
// flags and countdowns, sets every sample to released and restores the
// register defaults of 150, 20 and pressed-low.
`timescale 1ns / 1ps

module button_debounce_long_press_repeat_core #(
    parameter int BUTTONS    = bdlp_pkg::BUTTONS_DEF,
    parameter int TIMER_BITS = bdlp_pkg::TIMER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bdlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [bdlp_pkg::PIN_BITS-1:0]       s_pin_levels,
    input  logic [bdlp_pkg::IDX_BITS-1:0]       s_button_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_pressed,
    output logic [bdlp_pkg::LONG_BITS-1:0]      m_long_mode
);

    logic [bdlp_pkg::CFG_WIDTH-1:0] long_press_reg;
    logic [bdlp_pkg::CFG_WIDTH-1:0] repeat_reg;
    logic                           pressed_level_reg;

    logic                            accept;
    logic                            is_tick;
    logic                            is_read;
    logic [BUTTONS-1:0]              sel;
    logic [BUTTONS-1:0]              pins;
    logic [BUTTONS-1:0]              pending;
    logic [bdlp_pkg::LONG_BITS-1:0]  long_bits;
    bdlp_pkg::lane_status_t          status [BUTTONS];
    bdlp_pkg::result_t               result;
    bdlp_pkg::result_t               out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg    <= bdlp_pkg::LONG_PRESS_RST;
            repeat_reg        <= bdlp_pkg::REPEAT_RST;
            pressed_level_reg <= bdlp_pkg::PRESSED_RST;
        end else if (cfg_we) begin
            if (cfg_index == bdlp_pkg::REG_LONG_PRESS) begin
                long_press_reg <= cfg_wdata;
            end
            if (cfg_index == bdlp_pkg::REG_REPEAT) begin
                repeat_reg <= cfg_wdata;
            end
            if (cfg_index == bdlp_pkg::REG_PRESSED_LEVEL) begin
                pressed_level_reg <= cfg_wdata[0];
            end
        end
    end

    assign accept  = s_valid && s_ready;
    assign is_tick = accept && (s_command == bdlp_pkg::CMD_TICK);
    assign is_read = accept && (s_command == bdlp_pkg::CMD_READ);

    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        bdlp_pkg::lane_ctrl_t ctrl;

        if (i < bdlp_pkg::PIN_BITS) begin : g_pin
            assign pins[i] = s_pin_levels[i];
        end else begin : g_nopin
            assign pins[i] = 1'b0;
        end

        assign sel[i]             = (32'(s_button_index) == i);
        assign ctrl.tick          = is_tick;
        assign ctrl.clear         = is_read && sel[i];
        assign ctrl.pressed_level = pressed_level_reg;
        assign pending[i]         = status[i].pending;

        bdlp_lane #(
            .TIMER_BITS(TIMER_BITS)
        ) u_lane (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .ctrl            (ctrl),
            .pin             (pins[i]),
            .long_press_ticks(long_press_reg),
            .repeat_ticks    (repeat_reg),
            .status          (status[i])
        );
    end

    for (genvar j = 0; j < bdlp_pkg::LONG_BITS; j++) begin : g_long
        if (j < BUTTONS) begin : g_shown
            assign long_bits[j] = status[j].long_next;
        end else begin : g_absent
            assign long_bits[j] = 1'b0;
        end
    end

    assign result.pressed   = (s_command == bdlp_pkg::CMD_READ) && |(pending & sel);
    assign result.long_mode = long_bits;

    bdlp_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (result),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign m_pressed   = out_data.pressed;
    assign m_long_mode = out_data.long_mode;

endmodule

### hdl/bdlp_lane.sv
// One button lane: sample history, accepted level, press flag and countdown.
`timescale 1ns / 1ps

module bdlp_lane #(
    parameter int TIMER_BITS = bdlp_pkg::TIMER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdlp_pkg::lane_ctrl_t           ctrl,
    input  logic                           pin,
    input  logic [bdlp_pkg::CFG_WIDTH-1:0] long_press_ticks,
    input  logic [bdlp_pkg::CFG_WIDTH-1:0] repeat_ticks,
    output bdlp_pkg::lane_status_t         status
);

    logic                  middle_reg, middle_next;
    logic                  newest_reg, newest_next;
    logic                  accepted_reg, accepted_next;
    logic                  pending_reg, pending_next;
    logic                  long_reg, long_next;
    logic [TIMER_BITS-1:0] count_reg, count_next;
    logic [bdlp_pkg::TIMER_BITS_MAX-1:0] long_wide;
    logic [bdlp_pkg::TIMER_BITS_MAX-1:0] repeat_wide;
    logic [TIMER_BITS-1:0] long_load;
    logic [TIMER_BITS-1:0] repeat_load;

    assign long_wide   = bdlp_pkg::TIMER_BITS_MAX'(long_press_ticks);
    assign repeat_wide = bdlp_pkg::TIMER_BITS_MAX'(repeat_ticks);
    assign long_load   = long_wide[TIMER_BITS-1:0];
    assign repeat_load = repeat_wide[TIMER_BITS-1:0];

    always_comb begin
        middle_next   = middle_reg;
        newest_next   = newest_reg;
        accepted_next = accepted_reg;
        pending_next  = pending_reg;
        long_next     = long_reg;
        count_next    = count_reg;
        if (ctrl.tick) begin
            middle_next = newest_reg;
            newest_next = pin;
            if (middle_reg != newest_reg || newest_reg != pin) begin
                long_next = 1'b0;
            end else if (accepted_reg != pin) begin
                accepted_next = pin;
                if (pin == ctrl.pressed_level) begin
                    pending_next = 1'b1;
                    count_next   = long_reg ? repeat_load : long_load;
                end
            end else if (count_reg != '0) begin
                count_next = count_reg - TIMER_BITS'(1);
                if (count_reg == TIMER_BITS'(1)) begin
                    accepted_next = ~ctrl.pressed_level;
                    long_next     = 1'b1;
                end
            end
        end else if (ctrl.clear) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            middle_reg   <= bdlp_pkg::RELEASED_RST;
            newest_reg   <= bdlp_pkg::RELEASED_RST;
            accepted_reg <= bdlp_pkg::RELEASED_RST;
            pending_reg  <= 1'b0;
            long_reg     <= 1'b0;
            count_reg    <= '0;
        end else begin
            middle_reg   <= middle_next;
            newest_reg   <= newest_next;
            accepted_reg <= accepted_next;
            pending_reg  <= pending_next;
            long_reg     <= long_next;
            count_reg    <= count_next;
        end
    end

    assign status.pending   = pending_reg;
    assign status.long_next = long_next;

endmodule

### hdl/bdlp_skid.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module bdlp_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdlp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bdlp_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bdlp_pkg::result_t out_data_reg, out_data_next;
    bdlp_pkg::result_t skid_data_reg, skid_data_next;
    logic              in_fire;
    logic              out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = in_data;
                out_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/bdlp_checker.sv
// Port checker for the button debouncer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdlp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_pressed,
    input logic [bdlp_pkg::LONG_BITS-1:0] m_long_mode
);

    `BDLP_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid, "result shown after reset")

    `BDLP_ASSERT(a_accept_result, aclk, aresetn, s_valid && s_ready |=> m_valid, "accepted item gave no result")

    `BDLP_ASSERT(a_ready_drop, aclk, aresetn, $fell(s_ready) |-> $past(m_valid && !m_ready), "input stalled without a waiting result")

    `BDLP_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable({m_pressed, m_long_mode}), "stalled result changed")

endmodule

bind button_debounce_long_press_repeat_core bdlp_checker u_bdlp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pressed  (m_pressed),
    .m_long_mode(m_long_mode)
);
